[rtl/mi3_pkg.sv]
// Shared widths, latencies and cofactor index table for the 3x3 matrix inverse.
// Used by the cofactor, determinant and division lanes and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package mi3_pkg;

  localparam int EL_W          = 32;
  localparam int N_EL          = 9;
  localparam int FRAC_BITS_DEF = 16;
  localparam int PROD_W        = 2 * EL_W;
  localparam int COF_W         = 2 * EL_W + 1;
  localparam int CMAG_W        = 2 * EL_W;
  localparam int DS_W          = 3 * EL_W + 1;
  localparam int DW            = 3 * EL_W;
  localparam int QB            = EL_W + 2;
  localparam int COF_LAT       = 2;
  localparam int DET_LAT       = 4;
  localparam int PIPE_LAT      = COF_LAT + DET_LAT + QB + 2;

  // cofactor k = el[a] * el[b] - el[c] * el[d], element index is row * 3 + col
  localparam logic [3:0] COF_IDX [0:N_EL-1][0:3] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  typedef struct packed {
    logic [N_EL-1:0][EL_W-1:0] el;
    logic                      singular;
    logic                      saturated;
  } res_t;

endpackage
`default_nettype wire

[rtl/mi3_cof_lane.sv]
// One cofactor lane: two signed 32x32 products, then their exact difference.
// Depends on mi3_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mi3_cof_lane import mi3_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [EL_W-1:0]  a_i,
  input  logic signed [EL_W-1:0]  b_i,
  input  logic signed [EL_W-1:0]  c_i,
  input  logic signed [EL_W-1:0]  d_i,
  output logic signed [COF_W-1:0] cof_o
);

  logic signed [PROD_W-1:0] pab_r, pab_nxt, pcd_r, pcd_nxt;
  logic signed [COF_W-1:0]  cof_r, cof_nxt;

  always_comb begin
    pab_nxt = PROD_W'(a_i) * PROD_W'(b_i);
    pcd_nxt = PROD_W'(c_i) * PROD_W'(d_i);
    cof_nxt = COF_W'(pab_r) - COF_W'(pcd_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pab_r <= pab_nxt;
      pcd_r <= pcd_nxt;
      cof_r <= cof_nxt;
    end
  end

  assign cof_o = cof_r;

endmodule
`default_nettype wire

[rtl/mi3_det.sv]
// Determinant from row 0 and its three cofactors; returns magnitude, sign and zero.
// Depends on mi3_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mi3_det import mi3_pkg::*; (
  input  logic                       clk,
  input  logic                       en,
  input  logic [2:0][EL_W-1:0]       row0_i,
  input  logic [2:0][COF_W-1:0]      cof_i,
  output logic [DW-1:0]              dmag_o,
  output logic                       dneg_o,
  output logic                       dzero_o
);

  logic [2:0][EL_W-1:0]  a1_r, a2_r;
  logic [2:0][COF_W-1:0] ph_r, ph_nxt, pl_r, pl_nxt;
  logic [2:0][DS_W-1:0]  term_r, term_nxt;
  logic [DS_W-1:0]       det_r, det_nxt;
  logic [DW-1:0]         dmag_r, dmag_nxt;
  logic                  dneg_r, dzero_r;

  always_comb begin
    logic signed [COF_W-1:0] hi_x, lo_x, a_x;
    for (int k = 0; k < 3; k++) begin
      hi_x = COF_W'($signed(cof_i[k][COF_W-1:EL_W]));
      lo_x = COF_W'($signed({1'b0, cof_i[k][EL_W-1:0]}));
      a_x  = COF_W'($signed(a2_r[k]));
      ph_nxt[k]   = hi_x * a_x;
      pl_nxt[k]   = lo_x * a_x;
      term_nxt[k] = {ph_r[k][COF_W-1:0], {EL_W{1'b0}}}
                    + DS_W'($signed(pl_r[k]));
    end
    det_nxt  = term_r[0] + term_r[1] + term_r[2];
    dmag_nxt = det_r[DS_W-1] ? DW'(-det_r) : det_r[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r    <= row0_i;
      a2_r    <= a1_r;
      ph_r    <= ph_nxt;
      pl_r    <= pl_nxt;
      term_r  <= term_nxt;
      det_r   <= det_nxt;
      dmag_r  <= dmag_nxt;
      dneg_r  <= det_r[DS_W-1];
      dzero_r <= (det_r == '0);
    end
  end

  assign dmag_o  = dmag_r;
  assign dneg_o  = dneg_r;
  assign dzero_o = dzero_r;

endmodule
`default_nettype wire

[rtl/mi3_div_lane.sv]
// One division lane: pipelined restoring divide of a scaled cofactor by the
// determinant magnitude, then round half away from zero and saturate. Depends on mi3_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mi3_div_lane import mi3_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [COF_W-1:0]        cof_i,
  input  logic [QB:0][DW-1:0]     dmag_i,
  input  logic                    dneg_i,
  output logic [EL_W-1:0]         res_o,
  output logic                    sat_o
);

  localparam int NW    = CMAG_W + 2 * FRAC_BITS + 1;
  localparam int TW    = NW - QB;
  localparam int CMP_W = (TW > DW) ? TW : DW;
  localparam logic [QB-1:0] LIM_POS = QB'((64'd1 << (EL_W - 1)) - 64'd1);
  localparam logic [QB-1:0] LIM_NEG = QB'(64'd1 << (EL_W - 1));

  logic [COF_W-1:0]  cd_r [0:DET_LAT-2];
  logic [CMAG_W-1:0] cmag_r;
  logic              cneg_r;

  logic [DW-1:0]     rem_r  [0:QB];
  logic [QB-1:0]     q_r    [0:QB];
  logic [QB-1:0]     low_r  [0:QB];
  logic              ovf_r  [0:QB];
  logic              rneg_r [0:QB];

  logic [NW-1:0]     num;
  logic [CMP_W-1:0]  top_x, dmag_x;
  logic [QB:0]       q_p1;
  logic [QB-1:0]     mag, lim, mag_c;
  logic              sat_nxt;
  logic [EL_W-1:0]   res_nxt, res_r;
  logic              sat_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cd_r[0] <= cof_i;
      for (int k = 1; k < DET_LAT - 1; k++) begin
        cd_r[k] <= cd_r[k-1];
      end
      cneg_r <= cd_r[DET_LAT-2][COF_W-1];
      cmag_r <= cd_r[DET_LAT-2][COF_W-1] ? CMAG_W'(-cd_r[DET_LAT-2])
                                         : cd_r[DET_LAT-2][CMAG_W-1:0];
    end
  end

  always_comb begin
    num    = {cmag_r, {(2 * FRAC_BITS + 1){1'b0}}};
    top_x  = CMP_W'(num[NW-1:QB]);
    dmag_x = CMP_W'(dmag_i[0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= top_x[DW-1:0];
      q_r[0]    <= '0;
      low_r[0]  <= num[QB-1:0];
      ovf_r[0]  <= (top_x >= dmag_x);
      rneg_r[0] <= cneg_r ^ dneg_i;
    end
  end

  for (genvar s = 1; s <= QB; s++) begin : g_step
    logic [DW:0]   t, diff;
    logic          ge;
    logic [DW-1:0] rem_nxt;

    always_comb begin
      t       = {rem_r[s-1], low_r[s-1][QB-s]};
      diff    = t - {1'b0, dmag_i[s]};
      ge      = (t >= {1'b0, dmag_i[s]});
      rem_nxt = ge ? diff[DW-1:0] : t[DW-1:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt;
        q_r[s]    <= {q_r[s-1][QB-2:0], ge};
        low_r[s]  <= low_r[s-1];
        ovf_r[s]  <= ovf_r[s-1];
        rneg_r[s] <= rneg_r[s-1];
      end
    end
  end

  always_comb begin
    q_p1    = {1'b0, q_r[QB]} + (QB+1)'(1);
    mag     = q_p1[QB:1];
    lim     = rneg_r[QB] ? LIM_NEG : LIM_POS;
    sat_nxt = ovf_r[QB] | (mag > lim);
    mag_c   = sat_nxt ? lim : mag;
    res_nxt = rneg_r[QB] ? (~mag_c[EL_W-1:0] + EL_W'(1)) : mag_c[EL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign res_o = res_r;
  assign sat_o = sat_r;

endmodule
`default_nettype wire

[rtl/matrix_inverse_3x3.sv]
// Top level of the 3x3 matrix inverse: cofactor lanes, determinant, division
// lanes and the merging output stage. Depends on mi3_pkg, mi3_cof_lane, mi3_det and mi3_div_lane.
//
// Takes one 3x3 matrix of signed fixed-point elements per cycle while in_tready is high
// and returns its inverse, rounded half away from zero and saturated, with singular and
// saturated flags. A matrix passes the cofactor lanes, the determinant and the 34-stage
// restoring divider in each of the nine division lanes before the output register.
// Throughput is one matrix per cycle while out_tready stays high. An output
// register plus a one-item skid stage separate the two sides, so in_tready is
// registered and only drops once both hold a waiting result.
`timescale 1ns / 1ps
`default_nettype none
module matrix_inverse_3x3 import mi3_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [N_EL*EL_W-1:0]   in_tdata,   // in_r0c0, in_r0c1, ... in_r2c2
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [N_EL*EL_W-1:0]   out_tdata,  // inv_r0c0, inv_r0c1, ... inv_r2c2
  output logic [1:0]             out_tuser   // singular, saturated
);

  logic                  en;
  logic [EL_W-1:0]       el [0:N_EL-1];
  logic [COF_W-1:0]      cof [0:N_EL-1];
  logic [EL_W-1:0]       res [0:N_EL-1];
  logic [N_EL-1:0]       sat;
  logic [DW-1:0]         det_mag;
  logic                  det_neg, det_zero;
  logic [QB:1][DW-1:0]   dsh_r;
  logic [QB:0][DW-1:0]   dmag_p;
  logic                  vld_r [0:PIPE_LAT-1];
  logic                  dz_r  [0:QB+1];
  res_t                  merged, out_r, skid_r;
  logic                  out_v_r, skid_v_r, out_take;

  assign en        = !skid_v_r;
  assign in_tready = en;

  for (genvar k = 0; k < N_EL; k++) begin : g_el
    assign el[k] = in_tdata[k*EL_W +: EL_W];
  end

  for (genvar k = 0; k < N_EL; k++) begin : g_cof
    mi3_cof_lane u_cof (
      .clk   (clk),
      .en    (en),
      .a_i   ($signed(el[COF_IDX[k][0]])),
      .b_i   ($signed(el[COF_IDX[k][1]])),
      .c_i   ($signed(el[COF_IDX[k][2]])),
      .d_i   ($signed(el[COF_IDX[k][3]])),
      .cof_o (cof[k])
    );
  end

  mi3_det u_det (
    .clk     (clk),
    .en      (en),
    .row0_i  ({el[2], el[1], el[0]}),
    .cof_i   ({cof[6], cof[3], cof[0]}),
    .dmag_o  (det_mag),
    .dneg_o  (det_neg),
    .dzero_o (det_zero)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dsh_r[1] <= det_mag;
      for (int s = 2; s <= QB; s++) begin
        dsh_r[s] <= dsh_r[s-1];
      end
      dz_r[0] <= det_zero;
      for (int s = 1; s <= QB + 1; s++) begin
        dz_r[s] <= dz_r[s-1];
      end
    end
  end

  assign dmag_p = {dsh_r, det_mag};

  for (genvar k = 0; k < N_EL; k++) begin : g_div
    mi3_div_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk    (clk),
      .en     (en),
      .cof_i  (cof[k]),
      .dmag_i (dmag_p),
      .dneg_i (det_neg),
      .res_o  (res[k]),
      .sat_o  (sat[k])
    );
  end

  always_comb begin
    merged.singular  = dz_r[QB+1];
    merged.saturated = !dz_r[QB+1] && (|sat);
    for (int k = 0; k < N_EL; k++) begin
      merged.el[k] = dz_r[QB+1] ? '0 : res[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int i = 1; i < PIPE_LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  assign out_take = out_v_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_take) begin
        out_r    <= skid_r;
        skid_v_r <= 1'b0;
      end
    end else if (!out_v_r || out_take) begin
      out_v_r <= vld_r[PIPE_LAT-1];
      out_r   <= merged;
    end else if (vld_r[PIPE_LAT-1]) begin
      skid_r   <= merged;
      skid_v_r <= 1'b1;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r.el;
  assign out_tuser  = {out_r.saturated, out_r.singular};

endmodule
`default_nettype wire

[rtl/mi3_checker.sv]
// Port-level checks for the 3x3 matrix inverse, bound to its top level.
// Depends on matrix_inverse_3x3 port names only.
`timescale 1ns / 1ps
`default_nettype none
module mi3_checker (
  input wire         clk,
  input wire         rst_n,
  input wire         in_tready,
  input wire         out_tvalid,
  input wire         out_tready,
  input wire [287:0] out_tdata,
  input wire [1:0]   out_tuser
);

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> (out_tdata == '0) && !out_tuser[1])
    else $error("singular item carries data or saturation");

  a_stall_only_behind_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input held off with output empty");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled item changed");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("reset left an item or a stall behind");

endmodule

bind matrix_inverse_3x3 mi3_checker u_mi3_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

[bench/matrix_inverse_3x3_test.sv]
// Self-checking bench for matrix_inverse_3x3: directed and random matrices go in
// on the stream input, and each inverse is checked against a bit-exact predictor.
// Depends on mi3_pkg and the matrix_inverse_3x3 RTL.
`timescale 1ns / 1ps
module matrix_inverse_3x3_test;
  import mi3_pkg::*;

  localparam int ONE        = 1 << FRAC_BITS_DEF;
  localparam int N_RANDOM   = 2000;
  localparam int CALM_ITEMS = 300;
  localparam int STALL_LIM  = 4000;

  typedef logic [N_EL*EL_W-1:0] mat_t;
  typedef struct {
    mat_t       inv;
    logic [1:0] flags;  // singular, saturated
  } inverse_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  mat_t       in_tdata = '0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  mat_t       out_tdata;
  logic [1:0] out_tuser;

  mat_t     pending_mats[$];
  inverse_t expected_inverses[$];
  int       errors = 0;
  int       n_checked = 0;
  int       n_singular = 0;
  int       n_saturated = 0;
  int       in_gap = 0;
  int       out_gap = 0;
  int       quiet_cycles = 0;
  bit       calm = 1'b0;

  matrix_inverse_3x3 dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic inverse_t invert_matrix(mat_t m);
    logic signed [127:0] e[N_EL];
    logic signed [127:0] det, cof;
    logic [127:0]        dmag, num, q, mag, lim;
    logic                dneg, rneg;
    inverse_t            r;
    for (int i = 0; i < N_EL; i++) e[i] = $signed(m[i*EL_W +: EL_W]);
    det = e[0]*e[4]*e[8] + e[1]*e[5]*e[6] + e[2]*e[3]*e[7]
        - e[2]*e[4]*e[6] - e[1]*e[3]*e[8] - e[0]*e[5]*e[7];
    r.inv = '0;
    r.flags = 2'b00;
    if (det == 0) begin
      r.flags[0] = 1'b1;
      return r;
    end
    dneg = det < 0;
    dmag = dneg ? -det : det;
    for (int k = 0; k < N_EL; k++) begin
      cof = e[COF_IDX[k][0]] * e[COF_IDX[k][1]] - e[COF_IDX[k][2]] * e[COF_IDX[k][3]];
      num = (cof < 0) ? -cof : cof;
      num = num << (2 * FRAC_BITS_DEF + 1);
      q = num / dmag;
      rneg = (cof < 0) != dneg;
      lim = rneg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      mag = (q + 1) >> 1;
      if (mag > lim) begin
        mag = lim;
        r.flags[1] = 1'b1;
      end
      r.inv[k*EL_W +: EL_W] = rneg ? -mag[31:0] : mag[31:0];
    end
    return r;
  endfunction

  function automatic mat_t make_mat(int a0, int a1, int a2, int a3, int a4,
                                    int a5, int a6, int a7, int a8);
    return {a8, a7, a6, a5, a4, a3, a2, a1, a0};
  endfunction

  function automatic int small_fixed();
    return $signed($urandom_range(0, 16 * ONE)) - 8 * ONE;
  endfunction

  function automatic mat_t random_mat();
    mat_t m;
    int   kind, r1, r2, s;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < N_EL; i++) begin
      case (kind)
        0, 1:    m[i*EL_W +: EL_W] = $urandom();
        2:       m[i*EL_W +: EL_W] = $signed($urandom_range(0, 8)) - 4;
        3:       m[i*EL_W +: EL_W] = ($signed($urandom_range(0, 8)) - 4) * ONE;
        default: m[i*EL_W +: EL_W] = small_fixed();
      endcase
    end
    // copy a scaled row onto another to force a zero determinant
    if (kind == 3 || $urandom_range(0, 9) == 0) begin
      r1 = $urandom_range(0, 2);
      r2 = (r1 + $urandom_range(1, 2)) % 3;
      s = $signed($urandom_range(0, 4)) - 2;
      for (int c = 0; c < 3; c++)
        m[(r2*3+c)*EL_W +: EL_W] = s * $signed(m[(r1*3+c)*EL_W +: EL_W]);
    end
    return m;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_inverses.push_back(invert_matrix(in_tdata));
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_mats.size() > 0) begin
          in_tdata <= pending_mats.pop_front();
          in_tvalid <= 1'b1;
          calm = pending_mats.size() < CALM_ITEMS;
          if (!calm && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 10);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    inverse_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_inverses.size() == 0) begin
          $display("%0t: unexpected item: got %h flags %b", $time, out_tdata, out_tuser);
          errors++;
        end else begin
          want = expected_inverses.pop_front();
          n_checked++;
          if (want.flags[0]) n_singular++;
          if (want.flags[1]) n_saturated++;
          for (int k = 0; k < N_EL; k++)
            if (out_tdata[k*EL_W +: EL_W] !== want.inv[k*EL_W +: EL_W]) begin
              $display("%0t: element %0d expected %h actual %h", $time, k,
                       want.inv[k*EL_W +: EL_W], out_tdata[k*EL_W +: EL_W]);
              errors++;
            end
          if (out_tuser !== want.flags) begin
            $display("%0t: flags expected %b actual %b", $time, want.flags, out_tuser);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) out_gap = $urandom_range(1, 10);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIM) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIM);
      $display("matrix_inverse_3x3_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    pending_mats.push_back(make_mat(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
    pending_mats.push_back(make_mat(0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_mats.push_back(make_mat(2*ONE, 0, 0, 0, 4*ONE, 0, 0, 0, -ONE/2));
    pending_mats.push_back(make_mat(ONE, 2*ONE, 3*ONE, 4*ONE, 5*ONE, 6*ONE,
                                    7*ONE, 8*ONE, 9*ONE));
    pending_mats.push_back(make_mat(2*ONE, ONE, 0, ONE, 3*ONE, ONE, 0, ONE, 4*ONE));
    pending_mats.push_back(make_mat(1, 0, 0, 0, 1, 0, 0, 0, 1));
    pending_mats.push_back(make_mat(-1, 0, 0, 0, 1, 0, 0, 0, 1));
    pending_mats.push_back(make_mat(3, 0, 0, 0, 1, 1, 0, 1, 3));
    pending_mats.push_back(make_mat(32'h7FFFFFFF, 0, 0, 0, 32'h7FFFFFFF, 0,
                                    0, 0, 32'h7FFFFFFF));
    pending_mats.push_back(make_mat(32'h80000000, 0, 0, 0, 32'h80000000, 0,
                                    0, 0, 32'h80000000));
    pending_mats.push_back(make_mat(32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                                    32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                                    32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF));
    pending_mats.push_back(make_mat(-1, -1, -1, -1, -1, -1, -1, -1, -1));
    pending_mats.push_back(make_mat(-1, 0, 0, 0, -1, 0, 0, 0, -1));
    pending_mats.push_back(make_mat(3*ONE, 0, 0, 0, 3*ONE, 0, 0, 0, 3*ONE));
    pending_mats.push_back(make_mat(2, 1, 0, 1, 2, 0, 0, 0, 2));
    pending_mats.push_back(make_mat(4*ONE, 0, 0, 0, 0, ONE, 0, ONE, 0));
    pending_mats.push_back(make_mat(32'h55555555, 32'hAAAAAAAA, 1, 2, 3, 4,
                                    32'hFFFF0000, 32'h0000FFFF, 5));
    for (int i = 0; i < N_RANDOM; i++) pending_mats.push_back(random_mat());
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_mats.size() == 0 && !in_tvalid && expected_inverses.size() == 0);
    repeat (PIPE_LAT + 20) @(posedge clk);
    $display("checked %0d inverses, %0d singular and %0d saturated,", n_checked,
             n_singular, n_saturated);
    $display("with random stalls on both sides and a closing back-to-back stretch");
    if (errors == 0) begin
      $display("matrix_inverse_3x3_test: done, clean");
    end else begin
      $display("matrix_inverse_3x3_test: done, errors");
    end
    $finish;
  end
endmodule
